FILE: rtl/core/nalr_pkg.sv
// Package for the NMEA acknowledgement line recognizer.
// Holds codes, field widths, the ack prefix table and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nalr_pkg;

    localparam int LINE_CHARS_DEF = 127;
    localparam int PREFIX_LEN     = 9;
    localparam int ID_W           = 14;
    localparam int TICK_W         = 20;
    localparam int CFG_DATA_W     = 20;
    localparam int ID_ACC_W       = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(1000);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_START = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_ACK      = 2'd0,
        ST_CKSUM    = 2'd1,
        ST_TIMEOUT  = 2'd2
    } status_t;

    typedef enum logic {
        CFG_EXPECTED_ID = 1'b0,
        CFG_TIMEOUT     = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_WANT_ID   = 3'd0,
        PH_ID        = 3'd1,
        PH_WANT_FLAG = 3'd2,
        PH_FLAG      = 3'd3,
        PH_DONE      = 3'd4,
        PH_FAIL      = 3'd5
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] ack_flag;
    } result_t;

    // "$PMTK001," by position
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = CH_DOLLAR;
            4'd1:    ch = 8'h50;
            4'd2:    ch = 8'h4D;
            4'd3:    ch = 8'h54;
            4'd4:    ch = 8'h4B;
            4'd5:    ch = 8'h30;
            4'd6:    ch = 8'h30;
            4'd7:    ch = 8'h31;
            4'd8:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // {is_hex, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nalr_item_if.sv
// Input channel: valid/ready handshake carrying mode and received byte.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface nalr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nalr_result_if.sv
// Result channel: valid/ready handshake carrying status and ack flag.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface nalr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] ack_flag;

    modport source (output valid, output status, output ack_flag, input ready);
    modport sink   (input valid, input status, input ack_flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nalr_line_parser.sv
// Line parser: arm/tick state and per-character sentence parse.
// Updates on each stepped request, produces the result combinationally.
// Depends on nalr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nalr_line_parser
    import nalr_pkg::*;
#(
    parameter int LineChars = LINE_CHARS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [1:0]          mode,
    input  wire logic [7:0]          data_byte,
    input  wire logic [ID_W-1:0]     expected_id,
    input  wire logic [TICK_W-1:0]   timeout_ticks,
    output result_t                  res
);

    localparam int CW = $clog2(LineChars + 1);

    logic                armed_reg,     armed_next;
    logic [TICK_W-1:0]   tick_reg,      tick_next;
    logic [CW-1:0]       char_cnt_reg,  char_cnt_next;
    logic                prefix_ok_reg, prefix_ok_next;
    logic [7:0]          xor_reg,       xor_next;
    logic                star_reg,      star_next;
    logic                hex_open_reg,  hex_open_next;
    logic [7:0]          sent_reg,      sent_next;
    phase_t              phase_reg,     phase_next;
    logic [ID_ACC_W-1:0] id_reg,        id_next;
    logic [7:0]          flag_reg,      flag_next;

    logic [TICK_W-1:0]   tick_inc;
    logic                digit;
    logic [4:0]          hex;
    logic [19:0]         id_acc;
    logic [11:0]         flag_acc;
    logic                line_ok;

    assign tick_inc = tick_reg + TICK_W'(1);
    assign digit    = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign hex      = hex_val(data_byte);
    assign id_acc   = ({4'd0, id_reg} * 20'd10) + {16'd0, data_byte[3:0]};
    assign flag_acc = ({4'd0, flag_reg} * 12'd10) + {8'd0, data_byte[3:0]};
    assign line_ok  = (char_cnt_reg >= CW'(PREFIX_LEN)) && prefix_ok_reg && star_reg;

    always_comb
    begin
        armed_next     = armed_reg;
        tick_next      = tick_reg;
        char_cnt_next  = char_cnt_reg;
        prefix_ok_next = prefix_ok_reg;
        xor_next       = xor_reg;
        star_next      = star_reg;
        hex_open_next  = hex_open_reg;
        sent_next      = sent_reg;
        phase_next     = phase_reg;
        id_next        = id_reg;
        flag_next      = flag_reg;
        res            = '0;

        if (step) begin
            case (mode)
                MODE_START:
                begin
                    armed_next     = 1'b1;
                    tick_next      = '0;
                    char_cnt_next  = '0;
                    prefix_ok_next = 1'b1;
                    xor_next       = '0;
                    star_next      = 1'b0;
                    hex_open_next  = 1'b0;
                    sent_next      = '0;
                    phase_next     = PH_WANT_ID;
                    id_next        = '0;
                    flag_next      = '0;
                end
                MODE_TICK:
                begin
                    if (armed_reg) begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_ticks) begin
                            armed_next   = 1'b0;
                            res.valid    = 1'b1;
                            res.status   = ST_TIMEOUT;
                        end
                    end
                end
                MODE_BYTE:
                begin
                    if (armed_reg) begin
                        if (data_byte == CH_LF) begin
                            if (line_ok) begin
                                if (xor_reg != sent_reg) begin
                                    res.valid  = 1'b1;
                                    res.status = ST_CKSUM;
                                end
                                else if ((phase_reg == PH_FLAG || phase_reg == PH_DONE)
                                         && id_reg == {2'b00, expected_id}) begin
                                    res.valid    = 1'b1;
                                    res.status   = ST_ACK;
                                    res.ack_flag = flag_reg;
                                end
                            end
                            if (res.valid) begin
                                armed_next = 1'b0;
                            end
                            char_cnt_next  = '0;
                            prefix_ok_next = 1'b1;
                            xor_next       = '0;
                            star_next      = 1'b0;
                            hex_open_next  = 1'b0;
                            sent_next      = '0;
                            phase_next     = PH_WANT_ID;
                            id_next        = '0;
                            flag_next      = '0;
                        end
                        else if (data_byte != CH_CR && char_cnt_reg < CW'(LineChars)) begin
                            if (char_cnt_reg < CW'(PREFIX_LEN)
                                && data_byte != prefix_char(char_cnt_reg[3:0])) begin
                                prefix_ok_next = 1'b0;
                            end
                            // checksum covers everything between the dollar sign and the star
                            if (char_cnt_reg != '0) begin
                                if (star_reg) begin
                                    if (hex_open_reg) begin
                                        if (!hex[4]) begin
                                            hex_open_next = 1'b0;
                                        end
                                        else begin
                                            sent_next = {sent_reg[3:0], hex[3:0]};
                                        end
                                    end
                                end
                                else if (data_byte == CH_STAR) begin
                                    star_next     = 1'b1;
                                    hex_open_next = 1'b1;
                                end
                                else begin
                                    xor_next = xor_reg ^ data_byte;
                                end
                            end
                            if (char_cnt_reg >= CW'(PREFIX_LEN)) begin
                                case (phase_reg)
                                    PH_WANT_ID:
                                    begin
                                        if (digit) begin
                                            id_next    = {12'd0, data_byte[3:0]};
                                            phase_next = PH_ID;
                                        end
                                        else begin
                                            phase_next = PH_FAIL;
                                        end
                                    end
                                    PH_ID:
                                    begin
                                        if (digit) begin
                                            id_next = (id_acc > 20'd65535) ? 16'hFFFF
                                                                           : id_acc[15:0];
                                        end
                                        else if (data_byte == CH_COMMA) begin
                                            phase_next = PH_WANT_FLAG;
                                        end
                                        else begin
                                            phase_next = PH_FAIL;
                                        end
                                    end
                                    PH_WANT_FLAG:
                                    begin
                                        if (digit) begin
                                            flag_next  = {4'd0, data_byte[3:0]};
                                            phase_next = PH_FLAG;
                                        end
                                        else begin
                                            phase_next = PH_FAIL;
                                        end
                                    end
                                    PH_FLAG:
                                    begin
                                        if (digit) begin
                                            flag_next = (flag_acc > 12'd255) ? 8'hFF
                                                                             : flag_acc[7:0];
                                        end
                                        else begin
                                            phase_next = PH_DONE;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                            char_cnt_next = char_cnt_reg + CW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            armed_reg     <= 1'b0;
            tick_reg      <= '0;
            char_cnt_reg  <= '0;
            prefix_ok_reg <= 1'b1;
            xor_reg       <= '0;
            star_reg      <= 1'b0;
            hex_open_reg  <= 1'b0;
            sent_reg      <= '0;
            phase_reg     <= PH_WANT_ID;
            id_reg        <= '0;
            flag_reg      <= '0;
        end
        else begin
            armed_reg     <= armed_next;
            tick_reg      <= tick_next;
            char_cnt_reg  <= char_cnt_next;
            prefix_ok_reg <= prefix_ok_next;
            xor_reg       <= xor_next;
            star_reg      <= star_next;
            hex_open_reg  <= hex_open_next;
            sent_reg      <= sent_next;
            phase_reg     <= phase_next;
            id_reg        <= id_next;
            flag_reg      <= flag_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid |=> !armed_reg)
        else $error("result did not disarm");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode == MODE_START |=> armed_reg && char_cnt_reg == '0 && tick_reg == '0)
        else $error("start did not arm and clear");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> !res.valid)
        else $error("result while not armed");

    a_flag_only_ack: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != ST_ACK |-> res.ack_flag == 8'd0)
        else $error("nonzero flag on error result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/nalr_out_reg.sv
// Result output register on the result channel.
// Loads a parser result and holds it until the sink takes it.
// Depends on nalr_pkg and nalr_result_if.
`timescale 1ns / 1ps
`default_nettype none

module nalr_out_reg
    import nalr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire result_t  res,
    output logic          busy,
    nalr_result_if.source result
);

    logic       valid_reg, valid_next;
    logic [1:0] status_reg;
    logic [7:0] flag_reg;

    assign valid_next      = load || (valid_reg && !result.ready);
    assign busy            = valid_reg && !result.ready;
    assign result.valid    = valid_reg;
    assign result.status   = status_reg;
    assign result.ack_flag = flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            status_reg <= res.status;
            flag_reg   <= res.ack_flag;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nmea_ack_line_recognizer_top.sv
// Pipeline: an accepted request is registered in the input register; once the result register is free
// the parser steps on it, and its result is registered in the result register for the sink to take.
// Throughput: one request per cycle; ready drops only while a result waits on the sink.
// While the result register is held, the input register accepts a request only if it is empty.
// Reset (rst_n, async, low): idle/disarmed, empty line state, expected_id 0,
// timeout_ticks 1000, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module nmea_ack_line_recognizer_top
    import nalr_pkg::*;
#(
    parameter int LineChars = LINE_CHARS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    nalr_item_if.sink                  item,
    nalr_result_if.source              result
);

    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_mode_reg;
    logic [7:0]        s1_byte_reg;
    logic [ID_W-1:0]   expected_id_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic              out_busy;
    logic              advance;
    result_t           res;

    assign advance       = s1_valid_reg && !out_busy;
    assign item.ready    = !s1_valid_reg || advance;
    assign s1_valid_next = item.valid || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready) begin
            s1_mode_reg <= item.mode;
            s1_byte_reg <= item.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expected_id_reg <= '0;
            timeout_reg     <= TIMEOUT_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EXPECTED_ID: expected_id_reg <= cfg_data[ID_W-1:0];
                CFG_TIMEOUT:     timeout_reg     <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    nalr_line_parser #(
        .LineChars (LineChars)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .mode          (s1_mode_reg),
        .data_byte     (s1_byte_reg),
        .expected_id   (expected_id_reg),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    nalr_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && res.valid),
        .res    (res),
        .busy   (out_busy),
        .result (result)
    );

`ifndef NO_ASSERTIONS
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> s1_valid_reg && result.valid)
        else $error("input stalled without a held request");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_mode_reg))
        else $error("stalled request lost");
`endif

endmodule

`default_nettype wire
